>>> hw/rtl/companion_power_sequencer_unit_macros.svh
// Assertion macros for the companion power sequencer checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef COMPANION_POWER_SEQUENCER_UNIT_MACROS_SVH
`define COMPANION_POWER_SEQUENCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("companion power sequencer check failed");

// Consequent must hold in the cycle after the antecedent.
`define CPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("companion power sequencer check failed");

`endif

>>> hw/rtl/cps_pkg.sv
// Shared types, constants and helpers for the companion power sequencer.
// Used by the register file, the sequencer core and the top level.
package cps_pkg;

	localparam int TIME_BITS_DEF = 20;
	localparam int WAIT_W        = 16;
	localparam int PHASE_W       = 20;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;

	localparam logic [15:0]        DEBOUNCE_RST     = 16'd10;
	localparam logic [15:0]        EARLY_WINDOW_RST = 16'd100;
	localparam logic [15:0]        WAKE_PAUSE_RST   = 16'd1000;
	localparam logic [PHASE_W-1:0] CHECK_PERIOD_RST = 20'd600000;
	localparam logic [PHASE_W-1:0] CHECK_WINDOW_RST = 20'd2000;
	localparam logic [PHASE_W-1:0] UPD_TIMEOUT_RST  = 20'd60000;
	localparam logic [15:0]        RESTART_OFF_RST  = 16'd10;
	localparam logic [15:0]        UPDATE_OFF_RST   = 16'd1000;

	typedef enum logic [2:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_EARLY_WINDOW = 3'd1,
		REG_WAKE_PAUSE   = 3'd2,
		REG_CHECK_PERIOD = 3'd3,
		REG_CHECK_WINDOW = 3'd4,
		REG_UPD_TIMEOUT  = 3'd5,
		REG_RESTART_OFF  = 3'd6,
		REG_UPDATE_OFF   = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		STEP_IDLE        = 4'd0,
		STEP_DEBOUNCE    = 4'd1,
		STEP_RESTART_OFF = 4'd2,
		STEP_WAKE_RESUME = 4'd3,
		STEP_SETTLE      = 4'd4,
		STEP_WAKE_MANUAL = 4'd5,
		STEP_WAKE_UPDATE = 4'd6,
		STEP_CYCLE_OFF   = 4'd7
	} step_t;

	typedef struct packed {
		logic [15:0]        debounce_ms;
		logic [15:0]        early_window_ms;
		logic [15:0]        wake_pause_ms;
		logic [PHASE_W-1:0] check_period_ms;
		logic [PHASE_W-1:0] check_window_ms;
		logic [PHASE_W-1:0] update_timeout_ms;
		logic [15:0]        restart_off_ms;
		logic [15:0]        update_off_ms;
	} cfg_t;

	typedef struct packed {
		logic power;
		logic led;
		logic shut;
		logic upd;
	} pins_t;

	typedef struct packed {
		pins_t pins;
		logic  busy;
	} result_t;

	// A programmed length of zero still waits one tick.
	function automatic logic [WAIT_W-1:0] wait_len(input logic [15:0] len);
		logic [WAIT_W-1:0] r;
		r = (len == 16'd0) ? WAIT_W'(1) : WAIT_W'(len);
		return r;
	endfunction

endpackage

>>> hw/rtl/cps_regs.sv
// APB-style configuration register file for the companion power sequencer.
// Depends on cps_pkg for the register map and the configuration struct.
module cps_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cps_pkg::ADDR_W-1:0] paddr,
	input  logic [cps_pkg::DATA_W-1:0] pwdata,
	output logic [cps_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output cps_pkg::cfg_t              cfg
);
	import cps_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms       <= DEBOUNCE_RST;
			cfg_q.early_window_ms   <= EARLY_WINDOW_RST;
			cfg_q.wake_pause_ms     <= WAKE_PAUSE_RST;
			cfg_q.check_period_ms   <= CHECK_PERIOD_RST;
			cfg_q.check_window_ms   <= CHECK_WINDOW_RST;
			cfg_q.update_timeout_ms <= UPD_TIMEOUT_RST;
			cfg_q.restart_off_ms    <= RESTART_OFF_RST;
			cfg_q.update_off_ms     <= UPDATE_OFF_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DEBOUNCE:     cfg_q.debounce_ms       <= pwdata[15:0];
				REG_EARLY_WINDOW: cfg_q.early_window_ms   <= pwdata[15:0];
				REG_WAKE_PAUSE:   cfg_q.wake_pause_ms     <= pwdata[15:0];
				REG_CHECK_PERIOD: cfg_q.check_period_ms   <= pwdata[PHASE_W-1:0];
				REG_CHECK_WINDOW: cfg_q.check_window_ms   <= pwdata[PHASE_W-1:0];
				REG_UPD_TIMEOUT:  cfg_q.update_timeout_ms <= pwdata[PHASE_W-1:0];
				REG_RESTART_OFF:  cfg_q.restart_off_ms    <= pwdata[15:0];
				REG_UPDATE_OFF:   cfg_q.update_off_ms     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEBOUNCE:     prdata = DATA_W'(cfg_q.debounce_ms);
			REG_EARLY_WINDOW: prdata = DATA_W'(cfg_q.early_window_ms);
			REG_WAKE_PAUSE:   prdata = DATA_W'(cfg_q.wake_pause_ms);
			REG_CHECK_PERIOD: prdata = DATA_W'(cfg_q.check_period_ms);
			REG_CHECK_WINDOW: prdata = DATA_W'(cfg_q.check_window_ms);
			REG_UPD_TIMEOUT:  prdata = DATA_W'(cfg_q.update_timeout_ms);
			REG_RESTART_OFF:  prdata = DATA_W'(cfg_q.restart_off_ms);
			REG_UPDATE_OFF:   prdata = DATA_W'(cfg_q.update_off_ms);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/cps_seq.sv
// Sequencer core: state, wait counter, wake and period timers and pin levels.
// Advances by one tick per accepted item. Depends on cps_pkg.
module cps_seq #(
	parameter int TIME_BITS = cps_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick,
	input  logic             req,
	input  logic             btn,
	input  cps_pkg::cfg_t    cfg,
	output cps_pkg::result_t res_d
);
	import cps_pkg::*;

	localparam int CMP_W = (TIME_BITS > PHASE_W) ? TIME_BITS : PHASE_W;

	step_t              step_q, step_d;
	logic [WAIT_W-1:0]  wait_q, wait_d, wc_dec;
	logic [TIME_BITS-1:0] since_q, since_d, sw_inc;
	logic [PHASE_W-1:0] phase_q, phase_d, phase_nx, period;
	logic [PHASE_W:0]   phase_inc;
	logic               powered_q, powered_d, upd_mode_q, upd_mode_d;
	pins_t              pins_q, pins_d;
	logic               early, timed_out, in_window, wait_end;
	logic               chk_wake_man, chk_shut_req, chk_wake_upd, chk_cycle;

	// Timers advance before any decision in the tick, so decisions see the new values.
	assign sw_inc    = (since_q == {TIME_BITS{1'b1}}) ? since_q : since_q + TIME_BITS'(1);
	assign early     = CMP_W'(sw_inc) < CMP_W'(cfg.early_window_ms);
	assign timed_out = CMP_W'(sw_inc) > CMP_W'(cfg.update_timeout_ms);

	assign period    = (cfg.check_period_ms == '0) ? PHASE_W'(1) : cfg.check_period_ms;
	assign phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);
	assign phase_nx  = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[PHASE_W-1:0];
	assign in_window = phase_nx < cfg.check_window_ms;

	assign wc_dec   = (wait_q != '0) ? wait_q - WAIT_W'(1) : wait_q;
	assign wait_end = (wc_dec == '0);

	// Idle checks in priority order; a request outranks everything.
	assign chk_wake_man = !req && btn && !powered_q;
	assign chk_shut_req = !req && btn && powered_q;
	assign chk_wake_upd = !req && !btn && in_window && !powered_q;
	assign chk_cycle    = !req && !btn && powered_q && upd_mode_q && timed_out;

	always_comb begin
		step_d = step_q;
		wait_d = wait_q;
		if (tick) begin
			case (step_q)
				STEP_IDLE: begin
					if (req) begin
						step_d = STEP_DEBOUNCE;
						wait_d = wait_len(cfg.debounce_ms);
					end else if (chk_wake_man) begin
						step_d = STEP_WAKE_MANUAL;
						wait_d = wait_len(cfg.wake_pause_ms);
					end else if (chk_wake_upd) begin
						step_d = STEP_WAKE_UPDATE;
						wait_d = wait_len(cfg.wake_pause_ms);
					end else if (chk_cycle) begin
						step_d = STEP_CYCLE_OFF;
						wait_d = wait_len(cfg.update_off_ms);
					end
				end
				STEP_DEBOUNCE: begin
					wait_d = wc_dec;
					if (wait_end) begin
						step_d = STEP_IDLE;
						if (req && early) begin
							step_d = STEP_RESTART_OFF;
							wait_d = wait_len(cfg.restart_off_ms);
						end else if (req) begin
							step_d = STEP_SETTLE;
							wait_d = wait_len(cfg.debounce_ms);
						end
					end
				end
				STEP_RESTART_OFF, STEP_CYCLE_OFF: begin
					wait_d = wc_dec;
					if (wait_end) begin
						step_d = STEP_WAKE_RESUME;
						wait_d = wait_len(cfg.wake_pause_ms);
					end
				end
				STEP_WAKE_RESUME, STEP_SETTLE, STEP_WAKE_MANUAL, STEP_WAKE_UPDATE: begin
					wait_d = wc_dec;
					if (wait_end) begin
						step_d = STEP_IDLE;
					end
				end
				default: begin
					step_d = STEP_IDLE;
					wait_d = '0;
				end
			endcase
		end
	end

	always_comb begin
		pins_d     = pins_q;
		powered_d  = powered_q;
		upd_mode_d = upd_mode_q;
		since_d    = since_q;
		phase_d    = phase_q;
		if (tick) begin
			since_d = sw_inc;
			phase_d = phase_nx;
			case (step_q)
				STEP_IDLE: begin
					if (req) begin
						pins_d = pins_q;
					end else if (chk_wake_man) begin
						pins_d.upd   = 1'b0;
						pins_d.power = 1'b1;
						pins_d.shut  = 1'b0;
					end else if (chk_shut_req) begin
						pins_d.shut = 1'b1;
						pins_d.led  = 1'b1;
					end else if (chk_wake_upd) begin
						pins_d.power = 1'b1;
						pins_d.shut  = 1'b0;
						pins_d.upd   = 1'b1;
					end else if (chk_cycle) begin
						pins_d.power = 1'b0;
						pins_d.led   = 1'b1;
						pins_d.upd   = 1'b1;
					end
				end
				STEP_DEBOUNCE: begin
					if (wait_end && req && early) begin
						pins_d.power = 1'b0;
					end else if (wait_end && req) begin
						pins_d    = '0;
						powered_d = 1'b0;
					end
				end
				STEP_RESTART_OFF, STEP_CYCLE_OFF: begin
					if (wait_end) begin
						pins_d.power = 1'b1;
					end
				end
				STEP_WAKE_RESUME: begin
					if (wait_end) begin
						since_d = '0;
					end
				end
				STEP_WAKE_MANUAL: begin
					if (wait_end) begin
						powered_d  = 1'b1;
						upd_mode_d = 1'b0;
						since_d    = '0;
					end
				end
				STEP_WAKE_UPDATE: begin
					if (wait_end) begin
						powered_d  = 1'b1;
						upd_mode_d = 1'b1;
						since_d    = '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res_d.pins = pins_d;
	assign res_d.busy = (step_d != STEP_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= STEP_IDLE;
			wait_q     <= '0;
			since_q    <= '0;
			phase_q    <= '0;
			powered_q  <= 1'b0;
			upd_mode_q <= 1'b0;
			pins_q     <= '0;
		end else begin
			step_q     <= step_d;
			wait_q     <= wait_d;
			since_q    <= since_d;
			phase_q    <= phase_d;
			powered_q  <= powered_d;
			upd_mode_q <= upd_mode_d;
			pins_q     <= pins_d;
		end
	end

endmodule

>>> hw/rtl/companion_power_sequencer_unit.sv
// Top level of the companion power sequencer: input stage, result stage, handshakes.
// Instantiates cps_regs and cps_seq; depends on cps_pkg.
//
//   channel  direction  handshake          payload
//   in       to block   in_valid/in_stall  request_level, button_pressed
//   out      from block out_valid/out_stall power_enable, led_on, shutdown_signal,
//                                          update_select, busy_res
//   config   to block   APB write/read     eight timing registers
//
// An item waits in the input stage until the result register can accept its result;
// the sequencer state updates once per item, as that result is loaded. One item is
// taken every cycle unless the input is stalled. Reset clears the valid flags and
// sequencer state and loads the default timings. A stalled result holds the input
// stage, and the input is stalled only while both stages are full.
module companion_power_sequencer_unit #(
	parameter int TIME_BITS = cps_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       request_level,
	input  logic                       button_pressed,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       power_enable,
	output logic                       led_on,
	output logic                       shutdown_signal,
	output logic                       update_select,
	output logic                       busy_res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cps_pkg::ADDR_W-1:0] paddr,
	input  logic [cps_pkg::DATA_W-1:0] pwdata,
	output logic [cps_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import cps_pkg::*;

	cfg_t    cfg;
	result_t res_d, res_s2;
	logic    valid_s1, req_s1, btn_s1, valid_s2;
	logic    advance, tick;

	assign advance  = !valid_s2 || !out_stall;
	assign tick     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	cps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cps_seq #(
		.TIME_BITS (TIME_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.req    (req_s1),
		.btn    (btn_s1),
		.cfg    (cfg),
		.res_d  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			valid_s2 <= tick || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= request_level;
			btn_s1 <= button_pressed;
		end
		if (tick) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid       = valid_s2;
	assign power_enable    = res_s2.pins.power;
	assign led_on          = res_s2.pins.led;
	assign shutdown_signal = res_s2.pins.shut;
	assign update_select   = res_s2.pins.upd;
	assign busy_res        = res_s2.busy;

endmodule

>>> hw/rtl/cps_checker.sv
// Port-level checks for the companion power sequencer, bound to the top level.
// Uses the assertion macros from companion_power_sequencer_unit_macros.svh.
`include "companion_power_sequencer_unit_macros.svh"

module cps_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic power_enable,
	input logic led_on,
	input logic shutdown_signal,
	input logic update_select,
	input logic busy_res
);

	// A result that is not taken stays on the port unchanged.
	`CPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(power_enable) && $stable(led_on) && $stable(shutdown_signal) && $stable(update_select) && $stable(busy_res))

	// The input side only backs up when a result is waiting to be taken.
	`CPS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

	// Outside a wait phase, update select and the shutdown request only appear with power on.
	`CPS_ASSERT_NOW(a_upd_power, out_valid && !busy_res && update_select, power_enable)
	`CPS_ASSERT_NOW(a_shut_power, out_valid && !busy_res && shutdown_signal, power_enable)

endmodule

bind companion_power_sequencer_unit cps_checker u_cps_checker (.*);
